FILE: src/slwl_pkg.sv
// Package for the sliding window log limiter: field widths, request codes,
// register indexes and the sequencer state type. No dependencies.
package slwl_pkg;

  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned WINDOW_W = 24;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned WAIT_W   = 24;

  // request codes; the spare code behaves as a probe
  localparam logic [TYPE_W-1:0] REQ_ADMIT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PROBE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 1'b1;

  localparam logic [LIMIT_W-1:0]  MAX_REQUESTS_RST = 11'd1024;
  localparam logic [WINDOW_W-1:0] WINDOW_MS_RST    = 24'd1000;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } seq_state_t;

endpackage

FILE: src/slwl_in_if.sv
// Request channel: valid/ready handshake carrying request type and timestamp.
// Depends on slwl_pkg.
interface slwl_in_if;
  import slwl_pkg::*;

  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, output req_type, output now_ms, input ready);
  modport sink   (input valid, input req_type, input now_ms, output ready);
endinterface

FILE: src/slwl_out_if.sv
// Result channel: valid/ready handshake carrying admission, count and wait.
// Depends on slwl_pkg.
interface slwl_out_if;
  import slwl_pkg::*;

  logic                valid;
  logic                ready;
  logic                admitted;
  logic [COUNT_W-1:0]  count_in_window;
  logic [WAIT_W-1:0]   wait_ms;

  modport source (output valid, output admitted, output count_in_window,
                  output wait_ms, input ready);
  modport sink   (input valid, input admitted, input count_in_window,
                  input wait_ms, output ready);
endinterface

FILE: src/slwl_ring.sv
// Timestamp ring storage: one write port, one read port, registered read data.
// No dependencies.
module slwl_ring #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/sliding_window_log_limiter_top.sv
// Sliding window log rate limiter, top level: sequencer, config registers,
// result register. Depends on slwl_pkg, slwl_in_if, slwl_out_if, slwl_ring.
//
//  channel | dir | handshake           | beat contents
//  --------+-----+---------------------+---------------------------------------
//  in_chan | in  | valid/ready         | req_type, now_ms
//  out_chan| out | valid/ready         | admitted, count_in_window, wait_ms
//  cfg_*   | in  | wr_en, no back-press| cfg_index, cfg_wdata
//
// For each item, the accept cycle issues the read of the oldest stamp, then
// the check state pops one entry a cycle through the single ring read port
// until the ring is empty or the oldest is young enough.
// The finishing cycle waits while the result register still holds an untaken
// beat; a new request is taken as soon as the sequencer is back in idle.
// Reset (synchronous, rst_n low) empties the ring via the count and index;
// ring contents are not cleared, since an entry is read only once written.
module sliding_window_log_limiter_top #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  slwl_in_if.sink                       in_chan,
  slwl_out_if.source                    out_chan,
  input  logic                          cfg_wr_en,
  input  logic [slwl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slwl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import slwl_pkg::*;

  // ring index width, held count width, sum width for wrap, compare width
  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // configuration
  logic [LIMIT_W-1:0]  max_requests_r;
  logic [WINDOW_W-1:0] window_ms_r;

  // sequencer and ring pointers
  seq_state_t          state_r, state_nxt;
  logic [IW-1:0]       oldest_r, oldest_nxt;
  logic [CW-1:0]       held_r, held_nxt;
  logic [TYPE_W-1:0]   type_r;
  logic [STAMP_W-1:0]  now_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic                admitted_r, admitted_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;

  // ring port
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       rd_addr;
  logic [STAMP_W-1:0]  rd_data;

  logic                in_fire, out_fire, out_blocked;
  logic [STAMP_W-1:0]  age;
  logic                pop, finish, admit;
  logic [IW-1:0]       oldest_inc;
  logic [SW-1:0]       tail_sum;
  logic [LW-1:0]       max_req_ext, limit, held_ext, held_fin_ext;
  logic [CW-1:0]       held_fin;
  logic [WAIT_W-1:0]   age_fin;

  assign in_fire     = in_chan.valid && in_chan.ready;
  assign out_fire    = out_valid_r && out_chan.ready;
  assign out_blocked = out_valid_r && !out_chan.ready;

  assign in_chan.ready            = (state_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.admitted        = admitted_r;
  assign out_chan.count_in_window = count_r;
  assign out_chan.wait_ms         = wait_r;

  // expiry test on the stamp read last cycle
  assign age = now_r - rd_data;
  assign pop = (state_r == ST_CHECK) && (held_r != '0)
               && (age >= STAMP_W'(window_ms_r));
  assign finish = (state_r == ST_CHECK) && !pop && !out_blocked;

  assign oldest_inc = (oldest_r == IW'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  // limit saturates at ring depth
  assign max_req_ext = LW'(max_requests_r);
  assign limit       = (max_req_ext > LW'(RING_DEPTH)) ? LW'(RING_DEPTH) : max_req_ext;
  assign held_ext    = LW'(held_r);
  assign admit       = (type_r == REQ_ADMIT) && (held_ext < limit);

  // slot after the newest entry, wrapped once
  always_comb begin
    tail_sum = SW'(oldest_r) + SW'(held_r);
    if (tail_sum >= SW'(RING_DEPTH)) begin
      tail_sum = tail_sum - SW'(RING_DEPTH);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_fire;
    admitted_nxt  = admitted_r;
    count_nxt     = count_r;
    wait_nxt      = wait_r;
    rd_addr       = oldest_r;
    wr_en         = 1'b0;
    wr_addr       = tail_sum[IW-1:0];
    held_fin      = held_r;
    held_fin_ext  = held_ext;
    age_fin       = '0;

    if (pop) begin
      oldest_nxt = oldest_inc;
      held_nxt   = held_r - 1'b1;
      rd_addr    = oldest_inc;
    end else if (finish) begin
      // an empty ring before admission means the new entry is the oldest
      age_fin = (held_r == '0) ? '0 : age[WAIT_W-1:0];
      if (type_r == REQ_CLEAR) begin
        held_fin   = '0;
        oldest_nxt = '0;
      end else if (admit) begin
        held_fin = held_r + 1'b1;
        wr_en    = 1'b1;
      end
      held_fin_ext  = LW'(held_fin);
      held_nxt      = held_fin;
      out_valid_nxt = 1'b1;
      admitted_nxt  = admit;
      count_nxt     = held_fin_ext[COUNT_W-1:0];
      wait_nxt      = ((held_fin != '0) && (held_fin_ext >= limit))
                      ? window_ms_r - age_fin : '0;
    end
  end

  slwl_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (IW),
    .DW    (STAMP_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (now_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_requests_r <= MAX_REQUESTS_RST;
      window_ms_r    <= WINDOW_MS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_REQUESTS: max_requests_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_WINDOW_MS:    window_ms_r    <= cfg_wdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      type_r <= in_chan.req_type;
      now_r  <= in_chan.now_ms;
    end
    admitted_r <= admitted_nxt;
    count_r    <= count_nxt;
    wait_r     <= wait_nxt;
  end

`ifndef SYNTH
  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(RING_DEPTH))
    else $error("held count above ring depth");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> held_r == CW'($past(held_r) - 1'b1))
    else $error("pop did not drop held count by one");

  a_admit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && admitted_r) |-> (count_r != '0))
    else $error("admitted beat with empty count");

  a_wait_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (wait_r != '0)) |-> (count_r != '0))
    else $error("nonzero wait with empty ring");
`endif

endmodule

FILE: tb/tb_sliding_window_log_limiter_top.sv
// Self-checking bench for sliding_window_log_limiter_top: directed table, then random phases.
// Depends on slwl_pkg, slwl_in_if, slwl_out_if and the limiter RTL.
module tb_sliding_window_log_limiter_top;
  import slwl_pkg::*;

  // The spare request code has no name in the package. It is handled as a probe.
  localparam logic [TYPE_W-1:0] REQ_SPARE = 2'd3;

  // Ring depth of the instance (parameter left at its default).
  localparam int unsigned         RING_SLOTS   = 1024;
  localparam logic [LIMIT_W-1:0]  RING_CAP     = 11'd1024;

  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;  // worst item pops the whole ring, plus stalls
  localparam int unsigned LONG_HOLD_AFTER  = 60;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slwl_in_if  in_chan ();
  slwl_out_if out_chan ();

  sliding_window_log_limiter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // One result beat, as the block presents it.
  typedef struct packed {
    logic               admitted;
    logic [COUNT_W-1:0] count;
    logic [WAIT_W-1:0]  wait_ms;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Own model of the limiter: stamp ring, oldest slot, occupancy and registers.
  // Stamps are used only from slots that have been written.
  // ---------------------------------------------------------------------------
  logic [STAMP_W-1:0]  stamp_store [RING_SLOTS];
  logic [9:0]          oldest_slot = '0;
  logic [COUNT_W-1:0]  held_stamps = '0;
  logic [LIMIT_W-1:0]  cap_reg     = MAX_REQUESTS_RST;
  logic [WINDOW_W-1:0] span_reg    = WINDOW_MS_RST;

  // Expected results in arrival order; a small ring is plenty, since the block
  // holds at most one beat in flight and one in its result register.
  localparam int unsigned VERDICT_SLOTS = 16;
  verdict_t    verdict_fifo [VERDICT_SLOTS];
  int unsigned verdict_wr = 0;
  int unsigned verdict_rd = 0;
  int unsigned verdicts_taken = 0;
  int unsigned fail_count     = 0;
  logic [STAMP_W-1:0] clock_ms = '0;

  function automatic int unsigned verdicts_pending();
    return verdict_wr - verdict_rd;
  endfunction

  function automatic void stash_verdict(verdict_t v);
    if (verdicts_pending() >= VERDICT_SLOTS) begin
      $error("expected-result store overflow");
      fail_count++;
    end
    verdict_fifo[verdict_wr[3:0]] = v;
    verdict_wr++;
  endfunction

  function automatic verdict_t take_verdict();
    verdict_t v;
    v = verdict_fifo[verdict_rd[3:0]];
    verdict_rd++;
    return v;
  endfunction

  function automatic verdict_t judge_request(logic [TYPE_W-1:0] req, logic [STAMP_W-1:0] stamp);
    verdict_t           v;
    logic [LIMIT_W-1:0] cap;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] left;
    logic [9:0]         slot;
    v   = '0;
    cap = (cap_reg > RING_CAP) ? RING_CAP : cap_reg;
    // expiry first, on wrapped 32-bit ages
    age = stamp - stamp_store[oldest_slot];
    while (held_stamps != 0 && age >= {8'd0, span_reg}) begin
      oldest_slot = oldest_slot + 10'd1;
      held_stamps = held_stamps - 11'd1;
      age = stamp - stamp_store[oldest_slot];
    end
    if (req == REQ_CLEAR) begin
      held_stamps = '0;
      oldest_slot = '0;
    end else if (req == REQ_ADMIT && held_stamps < cap) begin
      slot = oldest_slot + held_stamps[9:0];
      stamp_store[slot] = stamp;
      held_stamps = held_stamps + 11'd1;
      v.admitted = 1'b1;
    end
    if (held_stamps != 0 && held_stamps >= cap) begin
      left = {8'd0, span_reg} - (stamp - stamp_store[oldest_slot]);
      v.wait_ms = left[WAIT_W-1:0];
    end
    v.count = held_stamps;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Request rows with 'typed' set carry the result written out
  // by hand; the others are predicted. Config rows write value[23:0].
  // ---------------------------------------------------------------------------
  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [TYPE_W-1:0]    req;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          value;
    logic                 typed;
    verdict_t             verdict;
  } row_t;

  localparam int unsigned DIRECTED_ROWS_N = 29;
  localparam row_t DIRECTED_ROWS [DIRECTED_ROWS_N] = '{
    // out of reset: limit 1024, window 1000
    '{ROW_REQ, REQ_PROBE, CFG_MAX_REQUESTS, 32'h0000_0000, 1'b1, {1'b0, 11'd0, 24'd0}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h0000_0000, 1'b1, {1'b1, 11'd1, 24'd0}},
    // clear at the top timestamp: entry expires, ring emptied
    '{ROW_REQ, REQ_CLEAR, CFG_MAX_REQUESTS, 32'hFFFF_FFFF, 1'b1, {1'b0, 11'd0, 24'd0}},
    '{ROW_REQ, REQ_SPARE, CFG_MAX_REQUESTS, 32'h0000_0005, 1'b1, {1'b0, 11'd0, 24'd0}},
    '{ROW_CFG, REQ_PROBE, CFG_MAX_REQUESTS, 32'd2,         1'b0, '0},
    '{ROW_CFG, REQ_PROBE, CFG_WINDOW_MS,    32'd100,       1'b0, '0},
    // fill across the 32-bit wrap, then a refused attempt
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'hFFFF_FFF0, 1'b1, {1'b1, 11'd1, 24'd0}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'hFFFF_FFF8, 1'b1, {1'b1, 11'd2, 24'd92}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h0000_0004, 1'b1, {1'b0, 11'd2, 24'd80}},
    // second entry is exactly one window old: both go
    '{ROW_REQ, REQ_PROBE, CFG_MAX_REQUESTS, 32'd92,        1'b1, {1'b0, 11'd0, 24'd0}},
    // limit zero
    '{ROW_CFG, REQ_PROBE, CFG_MAX_REQUESTS, 32'd0,         1'b0, '0},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'd200,       1'b1, {1'b0, 11'd0, 24'd0}},
    // window zero: admitted entry still counted once
    '{ROW_CFG, REQ_PROBE, CFG_MAX_REQUESTS, 32'd1,         1'b0, '0},
    '{ROW_CFG, REQ_PROBE, CFG_WINDOW_MS,    32'd0,         1'b0, '0},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'd300,       1'b1, {1'b1, 11'd1, 24'd0}},
    '{ROW_REQ, REQ_PROBE, CFG_MAX_REQUESTS, 32'd300,       1'b1, {1'b0, 11'd0, 24'd0}},
    // widest window
    '{ROW_CFG, REQ_PROBE, CFG_WINDOW_MS,    32'hFF_FFFF,   1'b0, '0},
    '{ROW_CFG, REQ_PROBE, CFG_MAX_REQUESTS, 32'd3,         1'b0, '0},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h0000_0000, 1'b1, {1'b1, 11'd1, 24'd0}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h8000_0000, 1'b1, {1'b1, 11'd1, 24'd0}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h8000_0001, 1'b0, '0},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h8000_0002, 1'b1, {1'b1, 11'd3, 24'hFF_FFFD}},
    // limit dropped under the held count
    '{ROW_CFG, REQ_PROBE, CFG_MAX_REQUESTS, 32'd1,         1'b0, '0},
    '{ROW_REQ, REQ_PROBE, CFG_MAX_REQUESTS, 32'h8000_0010, 1'b1, {1'b0, 11'd3, 24'hFF_FFEF}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'h8000_0011, 1'b0, '0},
    // limit beyond ring depth saturates
    '{ROW_CFG, REQ_PROBE, CFG_MAX_REQUESTS, 32'd2047,      1'b0, '0},
    '{ROW_CFG, REQ_PROBE, CFG_WINDOW_MS,    32'd1000,      1'b0, '0},
    '{ROW_REQ, REQ_CLEAR, CFG_MAX_REQUESTS, 32'h0000_0000, 1'b1, {1'b0, 11'd0, 24'd0}},
    '{ROW_REQ, REQ_ADMIT, CFG_MAX_REQUESTS, 32'hFFFF_FFFF, 1'b0, '0}
  };

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. valid is left high after a beat so that back-to-back beats
  // need no second assignment in the same step; only a gap or a drain lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [TYPE_W-1:0] req, logic [STAMP_W-1:0] stamp,
                              logic typed, verdict_t typed_verdict);
    verdict_t v;
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= req;
    in_chan.now_ms   <= stamp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    v = judge_request(req, stamp);  // state advances either way
    stash_verdict(typed ? typed_verdict : v);
  endtask

  task automatic idle_sender();
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender stops and waits for every outstanding result; the block is then idle.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (verdicts_pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MAX_REQUESTS) begin
      cap_reg = data[LIMIT_W-1:0];
    end else begin
      span_reg = data[WINDOW_W-1:0];
    end
    @(posedge clk);
  endtask

  // One random phase: program both registers while idle, then a run of beats
  // with timestamps creeping forward, odd jumps anywhere in 32 bits unless admit_only.
  task automatic run_phase(logic [LIMIT_W-1:0] cap, logic [WINDOW_W-1:0] span,
                           int unsigned n_items, int unsigned step_max, bit admit_only);
    logic [TYPE_W-1:0] req;
    int unsigned       roll;
    drain_results();
    write_reg(CFG_MAX_REQUESTS, {13'd0, cap});
    write_reg(CFG_WINDOW_MS, span);
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (admit_only || roll < 70)  req = REQ_ADMIT;
      else if (roll < 84)           req = REQ_PROBE;
      else if (roll < 92)           req = REQ_SPARE;
      else                          req = REQ_CLEAR;
      if (!admit_only && $urandom_range(0, 99) < 3) begin
        clock_ms = $urandom();
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      send_request(req, clock_ms, 1'b0, '0);
      idle_sender();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, random phases, then wind down.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [LIMIT_W-1:0]  cap;
    logic [WINDOW_W-1:0] span;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.req_type <= REQ_PROBE;
    in_chan.now_ms   <= '0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= CFG_MAX_REQUESTS;
    cfg_wdata        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS_N; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        drain_results();
        write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value[CFG_DATA_W-1:0]);
      end else begin
        send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].value,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].verdict);
        idle_sender();
      end
    end

    clock_ms = $urandom();
    run_phase(11'd4,  24'd50,  80, 20, 1'b0);  // long receiver hold-off lands here
    run_phase(11'd1,  24'd1,   40, 2,  1'b0);
    run_phase(11'd0,  24'd300, 20, 10, 1'b0);  // nothing admitted
    clock_ms = 32'hFFF0_0000;                  // run through the wrap
    run_phase(11'd16, 24'hFF_FFFF, 60, 32'h0010_0000, 1'b0);
    run_phase(11'd5,  24'd0,   30, 3,  1'b0);  // zero window
    // Fill a large part of the ring with a limit above its depth, then starve
    // it with a low limit, then shrink the window so one beat pops nearly
    // every entry.
    run_phase(11'd2047, 24'hFF_FFFF, 400, 1, 1'b1);
    run_phase(11'd3,    24'hFF_FFFF, 12,  1, 1'b0);
    run_phase(11'd4,    24'd50,      40, 20, 1'b0);
    run_phase(11'd1024, 24'd700,     60, 25, 1'b0);
    repeat (3) begin
      cap  = LIMIT_W'($urandom_range(1, 12));
      span = WINDOW_W'($urandom_range(1, 400));
      run_phase(cap, span, 30, span / 4 + 1, 1'b0);
    end
    drain_results();

    if (fail_count == 0 && verdicts_pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off while the sender
  // keeps offering, so the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : verdict_sink
    int unsigned hold_len;
    int unsigned run_len;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && verdicts_taken >= LONG_HOLD_AFTER) begin
        hold_len       = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else begin
        hold_len = pick_gap();
      end
      run_len = $urandom_range(1, 48);
      if (hold_len != 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
    end
  end

  // Every result beat against the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      verdicts_taken++;
      if (verdicts_pending() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = take_verdict();
        if (out_chan.admitted !== want.admitted) begin
          $error("admitted: expected %0d, got %0d", want.admitted, out_chan.admitted);
          fail_count++;
        end
        if (out_chan.count_in_window !== want.count) begin
          $error("count_in_window: expected %0d, got %0d", want.count,
                 out_chan.count_in_window);
          fail_count++;
        end
        if (out_chan.wait_ms !== want.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", want.wait_ms, out_chan.wait_ms);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no beat on either channel means a hang.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

FILE: sliding_window_log_limiter_top.f
src/slwl_pkg.sv
src/slwl_in_if.sv
src/slwl_out_if.sv
src/slwl_ring.sv
src/sliding_window_log_limiter_top.sv
tb/tb_sliding_window_log_limiter_top.sv
